/* rtl/msub_pkg.sv */
// Shared constants and types of the multi-pattern byte substitution unit.
package msub_pkg;

    localparam int C_REG_W   = 64;
    localparam int C_ADDR_W  = 6;
    localparam int C_CNT_W   = 3;
    localparam int C_LEN_LSB = 56;
    localparam int C_REP_MAX = 7;
    localparam int C_REP_W   = 8 * (C_REP_MAX - 1);

    typedef struct packed {
        logic               fin;
        logic [C_CNT_W-1:0] fill;
    } t_job_ctl;

endpackage

/* rtl/msub_front.sv */
// Front end: look-ahead window fill and job issue toward the job queue.
module msub_front import msub_pkg::*; #(
    parameter int MAX_PATTERN_LEN = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_final_byte,
    input  logic                            i_q_full,
    output logic                            o_push,
    output logic [MAX_PATTERN_LEN-1:0][7:0] o_job_win,
    output t_job_ctl                        o_job_ctl
);

    logic [MAX_PATTERN_LEN-1:0][7:0] r_win;
    logic [MAX_PATTERN_LEN-1:0][7:0] win_app;
    logic [C_CNT_W-1:0]              r_fill;
    logic [C_CNT_W-1:0]              fill_inc;
    logic                            accept;
    logic                            full;

    always_comb begin
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            win_app[i] = (C_CNT_W'(i) == r_fill) ? i_data_byte : r_win[i];
        end
        fill_inc = r_fill + 1'b1;
        full     = (fill_inc == C_CNT_W'(MAX_PATTERN_LEN));
        accept   = i_in_valid && !i_q_full;
        o_push   = accept && (i_final_byte || full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (accept) begin
            if (i_final_byte) begin
                r_fill <= '0;
            end else if (full) begin
                r_fill <= C_CNT_W'(MAX_PATTERN_LEN - 1);
            end else begin
                r_fill <= fill_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!i_final_byte && full) begin
                r_win <= win_app >> 8;
            end else begin
                r_win <= win_app;
            end
        end
    end

    assign o_in_stall     = i_q_full;
    assign o_job_win      = win_app;
    assign o_job_ctl.fill = fill_inc;
    assign o_job_ctl.fin  = i_final_byte;

endmodule

/* rtl/msub_queue.sv */
// Two-entry job queue between the front end and the back end.
module msub_queue #(
    parameter int WIDTH = 60
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    logic [1:0][WIDTH-1:0] r_mem;
    logic                  r_wp;
    logic                  r_rp;
    logic [1:0]            r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

/* rtl/msub_back.sv */
// Back end: pattern match, replacement emission, flush and output register.
module msub_back import msub_pkg::*; #(
    parameter int PATTERNS        = 3,
    parameter int MAX_PATTERN_LEN = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [PATTERNS-1:0][C_REG_W-1:0] i_search_words,
    input  logic [PATTERNS-1:0][C_REG_W-1:0] i_replace_words,
    input  logic                            i_job_valid,
    input  logic [MAX_PATTERN_LEN-1:0][7:0] i_job_win,
    input  t_job_ctl                        i_job_ctl,
    output logic                            o_job_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_out_byte,
    output logic                            o_byte_present,
    output logic                            o_end_of_body
);

    logic [MAX_PATTERN_LEN-1:0][7:0] r_win, n_win;
    logic                            r_busy, n_busy;
    logic                            r_fin, n_fin;
    logic [C_CNT_W-1:0]              r_left, n_left;
    logic [C_CNT_W-1:0]              r_avail, n_avail;
    logic [C_CNT_W-1:0]              r_skip, n_skip;
    logic [C_REP_W-1:0]              r_rep, n_rep;
    logic [C_CNT_W-1:0]              r_rep_cnt, n_rep_cnt;
    logic [7:0]                      r_pend, n_pend;
    logic                            r_pend_v, n_pend_v;
    logic                            r_o_valid;
    logic [7:0]                      r_o_byte;
    logic                            r_o_pres;
    logic                            r_o_end;

    logic                            out_ready;
    logic                            can_go;
    logic                            any_hit;
    logic [C_CNT_W-1:0]              sel_len;
    logic [C_REG_W-1:0]              sel_rep;
    logic [C_CNT_W-1:0]              rl;
    logic                            emit_v;
    logic [7:0]                      emit_b;
    logic                            tail;
    logic                            done;
    logic                            pop;
    logic                            out_load;
    logic [7:0]                      out_b;
    logic                            out_p;
    logic                            out_e;

    assign out_ready = !r_o_valid || !i_out_stall;
    assign can_go    = r_busy && out_ready;

    // first enabled pattern in list order that matches at the oldest position
    always_comb begin
        logic [7:0] len;
        logic       ok;
        any_hit = 1'b0;
        sel_len = '0;
        sel_rep = '0;
        for (int p = PATTERNS - 1; p >= 0; p--) begin
            len = i_search_words[p][C_REG_W-1:C_LEN_LSB];
            ok  = (len != 8'd0) && (len <= 8'(MAX_PATTERN_LEN))
                  && (len <= {5'd0, r_avail});
            for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
                if ((8'(i) < len) && (r_win[i] != i_search_words[p][8*i +: 8])) begin
                    ok = 1'b0;
                end
            end
            if (ok) begin
                any_hit = 1'b1;
                sel_len = len[C_CNT_W-1:0];
                sel_rep = i_replace_words[p];
            end
        end
        if (sel_rep[C_REG_W-1:C_LEN_LSB] > 8'(C_REP_MAX)) begin
            rl = C_CNT_W'(C_REP_MAX);
        end else begin
            rl = sel_rep[C_LEN_LSB +: C_CNT_W];
        end
    end

    always_comb begin
        n_win     = r_win;
        n_busy    = r_busy;
        n_fin     = r_fin;
        n_left    = r_left;
        n_avail   = r_avail;
        n_skip    = r_skip;
        n_rep     = r_rep;
        n_rep_cnt = r_rep_cnt;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        emit_v    = 1'b0;
        emit_b    = r_win[0];
        tail      = 1'b0;

        if (can_go) begin
            if (r_rep_cnt != '0) begin
                emit_v    = 1'b1;
                emit_b    = r_rep[7:0];
                n_rep     = r_rep >> 8;
                n_rep_cnt = r_rep_cnt - 1'b1;
            end else if (r_left != '0) begin
                if (r_skip != '0) begin
                    n_skip = r_skip - 1'b1;
                end else if (any_hit) begin
                    emit_v    = (rl != '0);
                    emit_b    = sel_rep[7:0];
                    n_rep     = sel_rep[C_LEN_LSB-1:8];
                    n_rep_cnt = (rl != '0) ? rl - 1'b1 : '0;
                    n_skip    = sel_len - 1'b1;
                end else begin
                    emit_v = 1'b1;
                end
                n_win   = r_win >> 8;
                n_left  = r_left - 1'b1;
                n_avail = r_avail - 1'b1;
            end else if (r_fin) begin
                tail     = 1'b1;
                n_skip   = '0;
                n_pend_v = 1'b0;
            end
        end

        out_load = 1'b0;
        out_b    = emit_b;
        out_p    = 1'b1;
        out_e    = 1'b0;
        if (tail) begin
            out_load = 1'b1;
            out_b    = r_pend_v ? r_pend : 8'd0;
            out_p    = r_pend_v;
            out_e    = 1'b1;
        end else if (emit_v) begin
            if (r_fin) begin
                // hold the newest byte so the end mark can ride on it
                n_pend   = emit_b;
                n_pend_v = 1'b1;
                if (r_pend_v) begin
                    out_load = 1'b1;
                    out_b    = r_pend;
                end
            end else begin
                out_load = 1'b1;
            end
        end

        done = can_go && (tail || (!r_fin && n_left == '0 && n_rep_cnt == '0));
        if (done) begin
            n_busy = 1'b0;
        end
        pop = i_job_valid && (!r_busy || done);
        if (pop) begin
            n_busy  = 1'b1;
            n_win   = i_job_win;
            n_fin   = i_job_ctl.fin;
            n_avail = i_job_ctl.fill;
            n_left  = i_job_ctl.fin ? i_job_ctl.fill : C_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_left    <= '0;
            r_skip    <= '0;
            r_rep_cnt <= '0;
            r_pend_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_left    <= n_left;
            r_skip    <= n_skip;
            r_rep_cnt <= n_rep_cnt;
            r_pend_v  <= n_pend_v;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win   <= n_win;
        r_fin   <= n_fin;
        r_avail <= n_avail;
        r_rep   <= n_rep;
        r_pend  <= n_pend;
        if (out_load) begin
            r_o_byte <= out_b;
            r_o_pres <= out_p;
            r_o_end  <= out_e;
        end
    end

    assign o_job_pop      = pop;
    assign o_out_valid    = r_o_valid;
    assign o_out_byte     = r_o_byte;
    assign o_byte_present = r_o_pres;
    assign o_end_of_body  = r_o_end;

    a_skip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip <= C_CNT_W'(MAX_PATTERN_LEN - 1))
        else $error("skip count beyond window length");

    a_left_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left <= r_avail))
        else $error("positions left exceed visible bytes");

    a_pend_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_busy && r_fin))
        else $error("held byte outside a flush");

    a_idle_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_rep_cnt == '0))
        else $error("replacement bytes left while idle");

    a_tail_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail |=> (r_o_valid && r_o_end))
        else $error("flush ended without end mark");

endmodule

/* rtl/multi_pattern_byte_substitution_unit.sv */
// Top level of the multi-pattern byte substitution unit with its register file.
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+-------------------------------------
//   in       | i_in_valid / o_in_stall        | i_data_byte, i_final_byte
//   out      | o_out_valid / i_out_stall      | o_out_byte, o_byte_present,
//            |                                | o_end_of_body
//   config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata (64-bit)
//
// The back end handles one window position at a time and emits replacement bytes in turn.
// A final byte flushes every window position, with the replacement bytes of each match,
// and then ends with an end mark.
// A result passes through the job queue, the back-end window and the output register.
// Reset is synchronous and active low; registers and window fill return to zero.
// A stalled output holds the back end; a full two-entry job queue stalls the input.
module multi_pattern_byte_substitution_unit import msub_pkg::*; #(
    parameter int PATTERNS        = 3,
    parameter int MAX_PATTERN_LEN = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_data_byte,
    input  logic                i_final_byte,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_byte_present,
    output logic                o_end_of_body,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [C_ADDR_W-1:0] paddr,
    input  logic [C_REG_W-1:0]  pwdata,
    output logic [C_REG_W-1:0]  prdata,
    output logic                pready
);

    localparam int NREGS  = 2 * PATTERNS;
    localparam int JOB_W  = 8 * MAX_PATTERN_LEN + $bits(t_job_ctl);

    logic [NREGS-1:0][C_REG_W-1:0]     r_cfg;
    logic [PATTERNS-1:0][C_REG_W-1:0]  search_words;
    logic [PATTERNS-1:0][C_REG_W-1:0]  replace_words;
    logic [2:0]                        reg_idx;
    logic                              cfg_wr;

    logic                              q_full;
    logic                              q_valid;
    logic                              push;
    logic                              pop;
    logic [MAX_PATTERN_LEN-1:0][7:0]   push_win;
    t_job_ctl                          push_ctl;
    logic [JOB_W-1:0]                  q_data;
    logic [MAX_PATTERN_LEN-1:0][7:0]   job_win;
    t_job_ctl                          job_ctl;

    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            for (int k = 0; k < NREGS; k++) begin
                if (cfg_wr && reg_idx == 3'(k)) begin
                    r_cfg[k] <= pwdata;
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int k = 0; k < NREGS; k++) begin
            if (reg_idx == 3'(k)) begin
                prdata = r_cfg[k];
            end
        end
        for (int p = 0; p < PATTERNS; p++) begin
            search_words[p]  = r_cfg[2*p];
            replace_words[p] = r_cfg[2*p+1];
        end
    end

    msub_front #(
        .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_final_byte(i_final_byte),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job_win   (push_win),
        .o_job_ctl   (push_ctl)
    );

    msub_queue #(
        .WIDTH(JOB_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_data({push_ctl, push_win}),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_data     (q_data),
        .i_pop      (pop)
    );

    assign job_win = q_data[8*MAX_PATTERN_LEN-1:0];
    assign job_ctl = q_data[JOB_W-1:8*MAX_PATTERN_LEN];

    msub_back #(
        .PATTERNS       (PATTERNS),
        .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_search_words (search_words),
        .i_replace_words(replace_words),
        .i_job_valid    (q_valid),
        .i_job_win      (job_win),
        .i_job_ctl      (job_ctl),
        .o_job_pop      (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_end_of_body  (o_end_of_body)
    );

endmodule

/* tb/multi_pattern_byte_substitution_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the multi-pattern byte substitution unit.
module multi_pattern_byte_substitution_unit_test;
    import msub_pkg::*;

    localparam int N_PATTERNS    = 3;
    localparam int N_REGS        = 2 * N_PATTERNS;
    localparam int WINDOW_DEPTH  = 7;
    localparam int MAX_GAP       = 12;
    localparam int RANDOM_ITEMS  = 280;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PRINT_LIMIT   = 40;

    typedef enum int {
        REG_SEARCH_0,
        REG_REPLACE_0,
        REG_SEARCH_1,
        REG_REPLACE_1,
        REG_SEARCH_2,
        REG_REPLACE_2
    } t_reg_index;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       ends_body;
    } t_result;

    class substitution_scoreboard;
        logic [C_REG_W-1:0] reg_file [N_REGS];
        logic [7:0]         window [WINDOW_DEPTH];
        int unsigned        fill;
        int unsigned        skip;
        t_result            expected_bytes [$];
        int unsigned        mismatches;

        function new();
            foreach (reg_file[r]) reg_file[r] = '0;
            foreach (window[w]) window[w] = '0;
            fill       = 0;
            skip       = 0;
            mismatches = 0;
        endfunction

        function void set_register(t_reg_index index, logic [C_REG_W-1:0] value);
            reg_file[index] = value;
        endfunction

        function void push_result(logic [7:0] data, logic present, logic ends_body);
            t_result item;
            item.data      = data;
            item.present   = present;
            item.ends_body = ends_body;
            expected_bytes.push_back(item);
        endfunction

        function void resolve_head(int unsigned avail);
            logic [C_REG_W-1:0] search;
            logic [C_REG_W-1:0] replace;
            int unsigned        len;
            int unsigned        rep_len;
            bit                 hit;
            if (skip > 0) begin
                skip--;
                return;
            end
            for (int p = 0; p < N_PATTERNS; p++) begin
                search = reg_file[REG_SEARCH_0 + 2 * p];
                len    = search[C_LEN_LSB +: 8];
                if (len == 0 || len > WINDOW_DEPTH || len > avail) continue;
                hit = 1'b1;
                for (int i = 0; i < len; i++) begin
                    if (window[i] != search[8 * i +: 8]) hit = 1'b0;
                end
                if (hit) begin
                    replace = reg_file[REG_REPLACE_0 + 2 * p];
                    rep_len = replace[C_LEN_LSB +: 8];
                    if (rep_len > C_REP_MAX) rep_len = C_REP_MAX;
                    for (int i = 0; i < rep_len; i++) begin
                        push_result(replace[8 * i +: 8], 1'b1, 1'b0);
                    end
                    skip = len - 1;
                    return;
                end
            end
            push_result(window[0], 1'b1, 1'b0);
        endfunction

        function void drop_head();
            for (int i = 0; i + 1 < WINDOW_DEPTH; i++) window[i] = window[i + 1];
            if (fill > 0) fill--;
        endfunction

        function void note_request(logic [7:0] data, logic fin);
            int unsigned base_count;
            t_result     tail;
            base_count = expected_bytes.size();
            if (fill < WINDOW_DEPTH) begin
                window[fill] = data;
                fill++;
            end
            if (!fin) begin
                if (fill >= WINDOW_DEPTH) begin
                    resolve_head(fill);
                    drop_head();
                end
                return;
            end
            while (fill > 0) begin
                resolve_head(fill);
                drop_head();
            end
            skip = 0;
            if (expected_bytes.size() == base_count) begin
                push_result(8'h00, 1'b0, 1'b1);
            end else begin
                tail = expected_bytes.pop_back();
                tail.ends_body = 1'b1;
                expected_bytes.push_back(tail);
            end
        endfunction

        task report(string msg);
            if (mismatches < PRINT_LIMIT) $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(logic [7:0] data, logic present, logic ends_body);
            t_result want;
            if (expected_bytes.size() == 0) begin
                report($sformatf("unexpected result, byte %02h", data));
                return;
            end
            want = expected_bytes.pop_front();
            if (data !== want.data) begin
                report($sformatf("out_byte %02h, expected %02h", data, want.data));
            end
            if (present !== want.present) begin
                report($sformatf("byte_present %b, expected %b", present, want.present));
            end
            if (ends_body !== want.ends_body) begin
                report($sformatf("end_of_body %b, expected %b", ends_body, want.ends_body));
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                o_in_stall;
    logic [7:0]          i_data_byte    = '0;
    logic                i_final_byte   = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall    = 1'b0;
    logic [7:0]          o_out_byte;
    logic                o_byte_present;
    logic                o_end_of_body;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [C_ADDR_W-1:0] paddr          = '0;
    logic [C_REG_W-1:0]  pwdata         = '0;
    logic [C_REG_W-1:0]  prdata;
    logic                pready;

    substitution_scoreboard sub_sb;
    logic [C_REG_W-1:0]     pattern_regs [N_REGS];
    int unsigned            items_sent  = 0;
    int unsigned            cycle_count = 0;
    int unsigned            out_hold    = 0;
    bit                     steady_run  = 1'b0;

    multi_pattern_byte_substitution_unit #(
        .PATTERNS       (N_PATTERNS),
        .MAX_PATTERN_LEN(WINDOW_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_final_byte  (i_final_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_present(o_byte_present),
        .o_end_of_body (o_end_of_body),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                sub_sb.check_result(o_out_byte, o_byte_present, o_end_of_body);
                out_hold = steady_run ? 0 : $urandom_range(0, MAX_GAP);
            end
            @(negedge i_clk);
            if (out_hold > 0) begin
                i_out_stall = 1'b1;
                out_hold--;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    function automatic logic [C_REG_W-1:0] pattern_word(int unsigned len, string text);
        logic [C_REG_W-1:0] word;
        word = '0;
        word[C_LEN_LSB +: 8] = 8'(len);
        for (int i = 0; i < text.len() && i < WINDOW_DEPTH; i++) word[8 * i +: 8] = text[i];
        return word;
    endfunction

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(0, 4) == 0) return 8'($urandom);
        return 8'(8'h61 + $urandom_range(0, 3));
    endfunction

    function automatic logic [C_REG_W-1:0] random_word(bit letters);
        logic [C_REG_W-1:0] word;
        case ($urandom_range(0, 7))
            0:       word[C_LEN_LSB +: 8] = 8'd0;
            1:       word[C_LEN_LSB +: 8] = 8'($urandom_range(8, 255));
            default: word[C_LEN_LSB +: 8] = 8'($urandom_range(1, WINDOW_DEPTH));
        endcase
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            word[8 * i +: 8] = letters ? pick_letter() : 8'($urandom);
        end
        return word;
    endfunction

    task automatic write_register(input t_reg_index index, input logic [C_REG_W-1:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = C_ADDR_W'(8 * int'(index));
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sub_sb.set_register(index, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic program_patterns();
        for (int r = 0; r < N_REGS; r++) write_register(t_reg_index'(r), pattern_regs[r]);
    endtask

    task automatic push_request(input logic [7:0] data, input logic fin);
        int unsigned gap;
        gap = steady_run ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_data_byte  = data;
        i_final_byte = fin;
        do @(posedge i_clk); while (o_in_stall);
        sub_sb.note_request(data, fin);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_body(input logic [7:0] body [$]);
        steady_run = ($urandom_range(0, 3) == 0);
        foreach (body[i]) push_request(body[i], i == body.size() - 1);
    endtask

    task automatic send_random_body();
        logic [7:0]         body [$];
        logic [C_REG_W-1:0] search;
        int unsigned        want;
        int unsigned        len;
        int unsigned        cut;
        want = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        while (body.size() < want) begin
            search = pattern_regs[REG_SEARCH_0 + 2 * $urandom_range(0, N_PATTERNS - 1)];
            len    = search[C_LEN_LSB +: 8];
            case ($urandom_range(0, 3))
                0, 1: begin
                    if (len >= 1 && len <= WINDOW_DEPTH) begin
                        cut = ($urandom_range(0, 2) == 0) ? $urandom_range(1, len) : len;
                        for (int i = 0; i < cut; i++) body.push_back(search[8 * i +: 8]);
                    end else begin
                        body.push_back(pick_letter());
                    end
                end
                2:       body.push_back(pick_letter());
                default: body.push_back(8'($urandom));
            endcase
        end
        send_body(body);
    endtask

    task automatic drain_and_settle();
        i_in_valid = 1'b0;
        while (sub_sb.expected_bytes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [7:0] text [$];
        sub_sb = new();
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        pattern_regs[REG_SEARCH_0]  = pattern_word(3, "abc");
        pattern_regs[REG_REPLACE_0] = pattern_word(2, "XY");
        pattern_regs[REG_SEARCH_1]  = pattern_word(7, "0123456");
        pattern_regs[REG_REPLACE_1] = pattern_word(255, "ABCDEFG");
        pattern_regs[REG_SEARCH_2]  = pattern_word(1, "z");
        pattern_regs[REG_REPLACE_2] = pattern_word(0, "");
        program_patterns();
        text = '{8'h61, 8'h62, 8'h63};
        send_body(text);
        text = '{8'h7A};
        send_body(text);
        text = '{8'h61, 8'h62};
        send_body(text);
        text = '{8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36};
        send_body(text);
        text = '{8'h00, 8'hFF, 8'h7A, 8'h61, 8'h62, 8'h63, 8'h30, 8'h31, 8'h32, 8'h71};
        send_body(text);
        drain_and_settle();

        pattern_regs[REG_SEARCH_0]  = pattern_word(8, "abcdefg");
        pattern_regs[REG_REPLACE_0] = pattern_word(3, "XYZ");
        pattern_regs[REG_SEARCH_1]  = pattern_word(255, "abc");
        pattern_regs[REG_REPLACE_1] = pattern_word(1, "Q");
        pattern_regs[REG_SEARCH_2]  = pattern_word(0, "abc");
        pattern_regs[REG_REPLACE_2] = pattern_word(1, "R");
        program_patterns();
        text = '{8'h61, 8'h62, 8'h63};
        send_body(text);
        drain_and_settle();

        items_sent = 0;
        for (int phase = 0; items_sent < RANDOM_ITEMS; phase++) begin
            if (phase == 0) begin
                pattern_regs[REG_SEARCH_0]  = {8'd7, {7{8'hFF}}};
                pattern_regs[REG_REPLACE_0] = {8'd7, 56'h0};
                pattern_regs[REG_SEARCH_1]  = {8'd1, 56'h0};
                pattern_regs[REG_REPLACE_1] = {8'd255, {7{8'hFF}}};
                pattern_regs[REG_SEARCH_2]  = {8'd255, {7{8'h61}}};
                pattern_regs[REG_REPLACE_2] = '0;
            end else begin
                for (int p = 0; p < N_PATTERNS; p++) begin
                    pattern_regs[REG_SEARCH_0 + 2 * p]  = random_word(1'b1);
                    pattern_regs[REG_REPLACE_0 + 2 * p] = random_word(1'b0);
                end
            end
            program_patterns();
            repeat (4) send_random_body();
            drain_and_settle();
        end

        if (sub_sb.mismatches == 0 && sub_sb.expected_bytes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
